>>> rtl/core/pfrt_pkg.sv
`timescale 1ns / 1ps
package pfrt_pkg;
  localparam int FRAME_BUFFERS = 8;
  localparam int SLOT_W = $clog2(FRAME_BUFFERS);
  localparam int PIXELS = 65536;
  localparam logic [16:0] MISSING_RESET = 17'd9999;
  localparam logic [16:0] PPF_RESET = 17'd999;

  typedef enum logic [1:0] {
    OP_PACKET  = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MOD  = 4'b0100,
    ST_EXEC = 4'b1000
  } state_t;

  // frame bytes for a depth code; unsupported codes act as 12 bits
  function automatic logic [20:0] frame_bytes(input logic [4:0] depth);
    logic [20:0] r;
    case (depth)
      5'd1:    r = 21'(PIXELS / 8);
      5'd4:    r = 21'(PIXELS * 4 / 8);
      5'd6:    r = 21'(PIXELS * 6 / 8);
      default: r = 21'(PIXELS * 12 / 8);
    endcase
    return r;
  endfunction
endpackage

>>> rtl/core/pfrt_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module pfrt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [20:0] dividend,
  input  logic [16:0] divisor,
  output logic        busy,
  output logic [20:0] quotient,
  output logic [16:0] remainder
);
  import pfrt_pkg::*;
  logic [20:0] q_r, q_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] d_r, d_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [17:0] sh;
  logic [18:0] diff;

  always_comb begin
    sh = {rem_r[16:0], q_r[20]};
    diff = {1'b0, sh} - {2'b0, d_r};
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; d_nxt = divisor;
      cnt_nxt = 5'd21; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[18]) begin
        rem_nxt = diff[17:0]; q_nxt = {q_r[19:0], 1'b1};
      end else begin
        rem_nxt = sh; q_nxt = {q_r[19:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  assign busy = busy_r;
  assign quotient = q_r;
  assign remainder = rem_r[16:0];

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |-> cnt_r != 5'd0) else $error("divider count");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider not busy after start");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == 5'd1 && !start |=> !busy_r) else $error("divider end");
endmodule

>>> rtl/core/packet_frame_reassembly_tracker_top.sv
`timescale 1ns / 1ps
// Path from the accepting edge to out_tvalid: a packet passes DIV (divider pass for the
// sequence modulo) and EXEC; the first packet first divides for packets per frame; a frame
// start runs EXEC twice, and with a new payload size passes MOD (second pass for packets
// per frame) between them; other items go straight to EXEC.
// One item at a time; the next item is taken only after out_tready has accepted the result.
// Reset (rst_n, synchronous, low): all but item_r, pay_r, mod_r, odata_r to reset values.
module packet_frame_reassembly_tracker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  // sequence_number[15:0], shutter_count[31:16], payload_bytes[45:32]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // write_enable[0], write_slot[3:1], write_offset[20:4], capture_header[21],
  // frames_done[23:22], frames_overrun[25:24], frame_available[26],
  // read_slot[29:27], read_slot_high_counter[30], read_slot_missing[47:31],
  // packets_lost_total[79:48]
  output logic [79:0] out_tdata
);
  import pfrt_pkg::*;

  logic [4:0]  depth_r;
  state_t      st_r;
  logic [47:0] item_r;
  logic        seen_r;
  logic [15:0] cur_sh_r;
  logic [13:0] pay_r;
  logic [16:0] ppf_r;
  logic [16:0] exp_r;
  logic        hdr_r;
  logic [SLOT_W-1:0] head_r, tail_r;
  logic        empty_r;
  logic [16:0] miss_r [FRAME_BUFFERS];
  logic        hi_r   [FRAME_BUFFERS];
  logic [31:0] lost_r;
  logic [1:0]  tmo_r;
  logic        ovld_r;
  logic [79:0] odata_r;
  logic        ppf_pend_r;   // divide in ST_DIV computes ppf
  logic [16:0] mod_r;
  logic        dv_wait_r;    // launched divide not yet consumed

  logic [1:0]  op;
  logic [15:0] seq, sh;
  logic [13:0] pay;
  logic [15:0] seq0;
  assign op = item_r[1:0];
  assign seq = item_r[17:2];
  assign sh = item_r[33:18];
  assign pay = item_r[47:34];
  assign seq0 = seq - 16'd1;

  // shared divider
  logic        dv_start, dv_busy, dv_done;
  logic [20:0] dv_a, dv_q;
  logic [16:0] dv_b, dv_r;
  pfrt_div u_div (.clk, .rst_n, .start(dv_start), .dividend(dv_a), .divisor(dv_b),
                  .busy(dv_busy), .quotient(dv_q), .remainder(dv_r));

  // new ppf needed: first packet, or frame start with a changed payload size
  logic [16:0] ppf_q;
  logic [13:0] dv_pay;
  assign dv_pay = (pay == 14'd0) ? 14'd1 : pay;
  assign ppf_q = (dv_q == 21'd0) ? 17'd1 : dv_q[16:0];

  assign cfg_ready = (st_r == ST_IDLE) && !ovld_r;
  assign in_tready = (st_r == ST_IDLE) && !ovld_r && !cfg_valid;
  assign out_tvalid = ovld_r;
  assign out_tdata = odata_r;

  logic        acc;
  assign acc = in_tvalid && in_tready;

  // divider launch: ppf = (fb + d - 1)/d, else seq0 % ppf
  logic [20:0] fb;
  assign fb = frame_bytes(depth_r);
  always_comb begin
    dv_start = 1'b0; dv_a = '0; dv_b = '0;
    if (st_r == ST_DIV && !dv_wait_r) begin
      dv_start = 1'b1; dv_a = {5'd0, seq0}; dv_b = ppf_r;
    end else if (st_r == ST_IDLE && acc && in_tuser == OP_PACKET && !seen_r) begin
      dv_start = 1'b1;
      dv_a = fb + 21'(in_tdata[45:32] == 14'd0 ? 14'd1 : in_tdata[45:32]) - 21'd1;
      dv_b = {3'd0, in_tdata[45:32] == 14'd0 ? 14'd1 : in_tdata[45:32]};
    end else if (st_r == ST_MOD && !dv_wait_r) begin
      dv_start = 1'b1;
      dv_a = fb + 21'(dv_pay) - 21'd1;
      dv_b = {3'd0, dv_pay};
    end
  end

  // divide result pending until its state consumes it
  assign dv_done = dv_wait_r && !dv_busy;
  always_ff @(posedge clk) begin
    if (!rst_n) dv_wait_r <= 1'b0;
    else if (dv_start) dv_wait_r <= 1'b1;
    else if (dv_done) dv_wait_r <= 1'b0;
  end

  // execution of one item; the frame-start ppf recompute reenters EXEC
  logic        fs_r;      // second EXEC of a frame start
  always_ff @(posedge clk) begin
    logic [SLOT_W-1:0] h, t;
    logic        emp, hp, we, cap, fstart;
    logic [1:0]  dn, ov, tc;
    logic [16:0] mod, ex, ppf, woff, hd_miss, rmiss;
    logic [31:0] lost;
    logic [SLOT_W-1:0] ws;
    h = head_r; t = tail_r; emp = empty_r; hp = hdr_r;
    dn = '0; ov = '0; we = 1'b0; cap = 1'b0; ws = '0; woff = '0;
    mod = mod_r; ex = exp_r; ppf = ppf_r; lost = lost_r; tc = tmo_r; fstart = 1'b0;
    hd_miss = '0; rmiss = '0;
    if (!rst_n) begin
      depth_r <= 5'd12; st_r <= ST_IDLE; seen_r <= 1'b0; cur_sh_r <= '0;
      ppf_r <= PPF_RESET; exp_r <= '0; hdr_r <= 1'b1; head_r <= '0; tail_r <= '0;
      empty_r <= 1'b1; lost_r <= '0; tmo_r <= '0; ovld_r <= 1'b0; ppf_pend_r <= 1'b0;
      fs_r <= 1'b0;
      for (int i = 0; i < FRAME_BUFFERS; i++) begin
        miss_r[i] <= MISSING_RESET; hi_r[i] <= 1'b0;
      end
    end else begin
      if (ovld_r && out_tready) ovld_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (cfg_valid && cfg_ready) depth_r <= cfg_data;
          if (acc) begin
            item_r <= {in_tdata[45:0], in_tuser};
            if (in_tuser == OP_PACKET) begin
              st_r <= ST_DIV;
              ppf_pend_r <= !seen_r;
            end else st_r <= ST_EXEC;
          end
        end
        ST_DIV: begin
          if (dv_done && ppf_pend_r) begin
            // first packet: latch shutter, size and ppf
            ppf_pend_r <= 1'b0; seen_r <= 1'b1; cur_sh_r <= sh; pay_r <= pay;
            ppf_r <= ppf_q; miss_r[head_r] <= ppf_q;
          end else if (dv_done) begin
            mod_r <= (ppf_r == 17'd0) ? 17'd0 : dv_r;
            st_r <= ST_EXEC;
          end
        end
        ST_MOD: begin
          if (dv_done) begin
            ppf_r <= ppf_q; miss_r[head_r] <= ppf_q; st_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (op == OP_PACKET) begin
            fstart = !fs_r && (sh != cur_sh_r || mod < ex);
            if (fstart) begin
              cur_sh_r <= sh;
              if (ex != ppf) begin
                dn = dn + 2'd1; h = (h == SLOT_W'(FRAME_BUFFERS - 1)) ? '0 : h + 1'b1;
                emp = 1'b0;
                if (h == t) begin
                  ov = ov + 2'd1;
                  h = (h == '0) ? SLOT_W'(FRAME_BUFFERS - 1) : h - 1'b1;
                end
                hp = 1'b1;
                miss_r[h] <= ppf;
              end
              if ({1'b0, seq0} == ppf) hi_r[h] <= 1'b1;
              lost = lost + 32'(ppf) - 32'(ex) + 32'(mod);
              head_r <= h; empty_r <= emp; hdr_r <= hp; lost_r <= lost;
              if (pay_r != pay) begin
                pay_r <= pay; fs_r <= 1'b1; st_r <= ST_MOD;
              end else fs_r <= 1'b1;
              odata_r[25:22] <= {ov, dn};
            end else begin
              if (!fs_r && mod > ex) lost = lost + 32'(mod - ex);
              ex = mod + 17'd1;
              hd_miss = miss_r[h];
              if (mod < ppf) begin
                we = 1'b1; ws = h; woff = 17'(mod * 17'(pay_r));
                hd_miss = hd_miss - 17'd1;
              end
              if (hp) begin cap = 1'b1; hp = 1'b0; end
              if (fs_r) begin dn = odata_r[23:22]; ov = odata_r[25:24]; end
              if (ex == ppf) begin
                dn = dn + 2'd1; h = (h == SLOT_W'(FRAME_BUFFERS - 1)) ? '0 : h + 1'b1;
                emp = 1'b0;
                if (h == t) begin
                  ov = ov + 2'd1;
                  h = (h == '0) ? SLOT_W'(FRAME_BUFFERS - 1) : h - 1'b1;
                end
                hp = 1'b1;
                miss_r[h] <= ppf;
              end
              // countdown stands unless the handover reloads the same slot
              if (ex != ppf || h != head_r) miss_r[head_r] <= hd_miss;
              rmiss = (t == h) ? ((ex == ppf) ? ppf : hd_miss) :
                      (t == head_r) ? hd_miss : miss_r[t];
              fs_r <= 1'b0; exp_r <= ex; head_r <= h; empty_r <= emp; hdr_r <= hp;
              lost_r <= lost; st_r <= ST_IDLE; ovld_r <= 1'b1;
              odata_r <= {lost, rmiss, hi_r[t], 3'(t), !emp, ov, dn, cap, woff,
                          3'(ws), we};
            end
          end else begin
            if (op == OP_TIMEOUT) begin
              if (seen_r && ex != ppf) begin
                tc = tc + 2'd1;
                if (tc == 2'd2) begin
                  dn = 2'd1; h = (h == SLOT_W'(FRAME_BUFFERS - 1)) ? '0 : h + 1'b1;
                  emp = 1'b0;
                  if (h == t) begin
                    ov = 2'd1; h = (h == '0) ? SLOT_W'(FRAME_BUFFERS - 1) : h - 1'b1;
                  end
                  hp = 1'b1; miss_r[h] <= ppf; ex = ppf; tc = '0;
                end
              end else tc = '0;
            end else if (op == OP_RELEASE && !emp) begin
              hi_r[t] <= 1'b0;
              t = (t == SLOT_W'(FRAME_BUFFERS - 1)) ? '0 : t + 1'b1;
              if (t == h) emp = 1'b1;
            end
            rmiss = (dn != 2'd0 && t == h) ? ppf : miss_r[t];
            tmo_r <= tc; exp_r <= ex; head_r <= h; tail_r <= t; empty_r <= emp;
            hdr_r <= hp; st_r <= ST_IDLE; ovld_r <= 1'b1;
            odata_r <= {lost_r, rmiss, hi_r[t], 3'(t), !emp, ov, dn, 22'd0};
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_tready) else $error("ready while working");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r)) else $error("state not one-hot");
  a_emp: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> head_r == tail_r) else $error("empty ring with head off tail");
endmodule
